// ----- hw/rtl/gce_pkg.sv -----
// ----------------------------------------------------------------------------
// gce_pkg: shared widths and types for the grid cell enumerator
// Field widths, internal datapath widths and the divider control bundle.
// ----------------------------------------------------------------------------
package gce_pkg;

	// field widths
	localparam int COORD_W = 32;
	localparam int SIZE_W  = 30;
	localparam int CELL_W  = 31;

	// doubled-unit bound (2*center +/- size)
	localparam int BOUND_W = 34;
	// divider dividend, quotient and remainder
	localparam int DIVD_W  = 34;
	localparam int REM_W   = 33;
	localparam int DCNT_W  = $clog2(DIVD_W);
	// signed cell index, index span and coordinate accumulator
	localparam int IDX_W   = 35;
	localparam int SPAN_W  = 36;
	localparam int ACC_W   = 38;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_CELL_SIZE = 1'b0;
	localparam logic [CELL_W-1:0] CELL_RESET = 31'd65536;

	// divider lane control
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

// ----- hw/rtl/gce_div.sv -----
// ----------------------------------------------------------------------------
// gce_div: bit-serial restoring divider lane
// Shifts the dividend one bit per stepped cycle, one quotient bit per step.
// ----------------------------------------------------------------------------
module gce_div import gce_pkg::*; (
	input  logic              clk,
	input  div_ctrl_t         ctrl,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [CELL_W:0]   divisor,
	output logic [DIVD_W-1:0] quotient,
	output logic [REM_W-1:0]  remainder
);

	logic [REM_W-1:0]  rem_q;
	logic [DIVD_W-1:0] sh_q;
	logic [DIVD_W-1:0] partial;
	logic [DIVD_W:0]   trial;
	logic              fits;
	logic [REM_W-1:0]  rem_d;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		partial = {rem_q, sh_q[DIVD_W-1]};
		trial   = {1'b0, partial} - {{(DIVD_W - CELL_W){1'b0}}, divisor};
		fits    = ~trial[DIVD_W];
		rem_d   = fits ? trial[REM_W-1:0] : partial[REM_W-1:0];
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= '0;
			sh_q  <= dividend;
		end else if (ctrl.step) begin
			rem_q <= rem_d;
			sh_q  <= {sh_q[DIVD_W-2:0], fits};
		end
	end

	assign quotient  = sh_q;
	assign remainder = rem_q;

endmodule

// ----- hw/rtl/grid_cell_enumerator_core.sv -----
// ----------------------------------------------------------------------------
// grid_cell_enumerator_core: lists the fine grid cells inside a square
// Takes a square center and side, emits every cell of the configured size
// centered in the square, up to MAX_SPAN per axis; rows outer, columns inner.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_stall) carries one square request; the output
//   channel (out_valid/out_stall) returns one request per kept cell, the last
//   one flagged by last. A square with no kept cell returns a single request
//   with cell_valid low.
//   The cell size is written over the APB port while the block is idle.
// Timing
//   Four bound divisions run in parallel lanes, one quotient bit per cycle;
//   the states PREP, LOAD, DIV, FIN and SETUP come before the scan. The scan
//   visits one cell per cycle while it is not stalled (a row whose x falls
//   outside ends after its first cell); FLUSH then sends the final request.
//   One item is worked on at a time; in_stall is high while it is in flight.
// Reset and stall
//   Reset returns the block to idle, empties the output register and sets
//   the cell size to 1.0. A stalled output request holds; the scan waits on
//   a found cell while the output register stalls and the look-ahead is full.
// ----------------------------------------------------------------------------
module grid_cell_enumerator_core import gce_pkg::*; #(
	parameter int MAX_SPAN = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_AW-1:0]         paddr,
	input  logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]         prdata,
	output logic                      pready,
	// square requests
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic signed [COORD_W-1:0] center_z,
	input  logic [SIZE_W-1:0]         square_size,
	input  logic                      fill_traversable,
	// cell requests
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] cell_x,
	output logic signed [COORD_W-1:0] cell_y,
	output logic signed [COORD_W-1:0] cell_z,
	output logic                      blocked,
	output logic                      cell_valid,
	output logic                      truncated,
	output logic                      last
);

	localparam int CNT_W = $clog2(MAX_SPAN + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_SETUP = 3'd5;
	localparam logic [2:0] S_SCAN  = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	// clipped index count of one axis
	function automatic logic [CNT_W-1:0] span_count(input logic [SPAN_W-1:0] s);
		logic [CNT_W-1:0] n;
		if (s[SPAN_W-1]) begin
			n = '0;
		end else if (s >= SPAN_W'(MAX_SPAN)) begin
			n = CNT_W'(MAX_SPAN);
		end else begin
			n = s[CNT_W-1:0] + CNT_W'(1);
		end
		return n;
	endfunction

	// doubled units to Q15.16, floor and saturate
	function automatic logic [COORD_W-1:0] to_q16(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0]  h;
		logic [ACC_W-COORD_W:0]   top;
		logic [COORD_W-1:0]       r;
		h   = v >>> 1;
		top = h[ACC_W-1:COORD_W-1];
		if ((&top) || !(|top)) begin
			r = h[COORD_W-1:0];
		end else if (h[ACC_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	logic [2:0]              state_q;
	logic [CELL_W-1:0]       cell_size_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [SIZE_W-1:0]       sz_q;
	logic                    blk_q;
	logic [CELL_W-1:0]       ceff_q;
	logic [CELL_W:0]         two_c;
	logic signed [ACC_W-1:0] tce;
	logic signed [BOUND_W-1:0] bnd_q [4];
	logic [DIVD_W-1:0]       dvd [4];
	logic [DIVD_W-1:0]       quo [4];
	logic [REM_W-1:0]        rem [4];
	logic signed [IDX_W-1:0] idx_q [4];
	logic [DCNT_W-1:0]       dcnt_q;
	div_ctrl_t               dctrl;
	logic signed [ACC_W-1:0] v0x_q, v0y_q;
	logic signed [ACC_W-1:0] xr_q, yr_q;
	logic [CNT_W-1:0]        nx_q, ny_q, row_q, col_q;
	logic                    trunc_q;
	logic [SPAN_W-1:0]       span_x, span_y;
	logic [CNT_W-1:0]        nx_d, ny_d;
	logic signed [ACC_W-1:0] xadj, yadj;
	logic signed [ACC_W-1:0] bx_lo, bx_hi, by_lo, by_hi;
	logic                    x_ok, y_ok, found;
	logic                    out_free, scan_adv, push_pend, flush_go;
	logic                    pend_v_q;
	logic [COORD_W-1:0]      pend_x_q, pend_y_q;
	logic                    out_valid_q;
	logic [COORD_W-1:0]      cell_x_q, cell_y_q, cell_z_q;
	logic                    blocked_q, cell_valid_q, truncated_q, last_q;
	logic                    in_acc, cfg_wr;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[APB_AW-1] == REG_CELL_SIZE) ? {1'b0, cell_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CELL_RESET;
		end else if (cfg_wr && paddr[APB_AW-1] == REG_CELL_SIZE) begin
			cell_size_q <= pwdata[CELL_W-1:0];
		end
	end

	// input handshake
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q  <= center_x;
			cy_q  <= center_y;
			cz_q  <= center_z;
			sz_q  <= square_size;
			blk_q <= ~fill_traversable;
		end
	end

	assign two_c = {ceff_q, 1'b0};
	assign tce   = $signed({{(ACC_W - CELL_W - 1){1'b0}}, two_c});

	// bounds in doubled units and effective cell size
	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			ceff_q   <= (cell_size_q == '0) ? CELL_W'(1) : cell_size_q;
			bnd_q[0] <= {cx_q[COORD_W-1], cx_q, 1'b0} - {4'b0, sz_q};
			bnd_q[1] <= {cx_q[COORD_W-1], cx_q, 1'b0} + {4'b0, sz_q};
			bnd_q[2] <= {cy_q[COORD_W-1], cy_q, 1'b0} - {4'b0, sz_q};
			bnd_q[3] <= {cy_q[COORD_W-1], cy_q, 1'b0} + {4'b0, sz_q};
		end
	end

	// four division lanes: (|bound| + c) / 2c
	assign dctrl.load = (state_q == S_LOAD);
	assign dctrl.step = (state_q == S_DIV);

	for (genvar k = 0; k < 4; k++) begin : g_lane
		assign dvd[k] = bnd_q[k][BOUND_W-1]
			? {3'b0, ceff_q} - bnd_q[k]
			: bnd_q[k] + {3'b0, ceff_q};

		gce_div u_div (
			.clk       (clk),
			.ctrl      (dctrl),
			.dividend  (dvd[k]),
			.divisor   (two_c),
			.quotient  (quo[k]),
			.remainder (rem[k])
		);

		// signed index, rounded half away from zero
		always_ff @(posedge clk) begin
			if (state_q == S_FIN) begin
				idx_q[k] <= bnd_q[k][BOUND_W-1] ? -$signed({1'b0, quo[k]})
					: $signed({1'b0, quo[k]});
			end
		end
	end

	// first row and column coordinate from bound and remainder
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			v0x_q <= bnd_q[0][BOUND_W-1]
				? ACC_W'(bnd_q[0]) + $signed({5'b0, rem[0]}) - tce
				: ACC_W'(bnd_q[0]) - $signed({5'b0, rem[0]});
			v0y_q <= bnd_q[2][BOUND_W-1]
				? ACC_W'(bnd_q[2]) + $signed({5'b0, rem[2]}) - tce
				: ACC_W'(bnd_q[2]) - $signed({5'b0, rem[2]});
		end
	end

	// index spans and clipping
	always_comb begin
		span_x = {idx_q[1][IDX_W-1], idx_q[1]} - {idx_q[0][IDX_W-1], idx_q[0]};
		span_y = {idx_q[3][IDX_W-1], idx_q[3]} - {idx_q[2][IDX_W-1], idx_q[2]};
		nx_d   = span_count(span_x);
		ny_d   = span_count(span_y);
	end

	// candidate cell test against the exact bounds
	always_comb begin
		bx_lo = ACC_W'(bnd_q[0]);
		bx_hi = ACC_W'(bnd_q[1]);
		by_lo = ACC_W'(bnd_q[2]);
		by_hi = ACC_W'(bnd_q[3]);
		xadj  = xr_q[ACC_W-1] ? xr_q + tce : xr_q;
		yadj  = yr_q[ACC_W-1] ? yr_q + tce : yr_q;
		x_ok  = (xadj >= bx_lo) && (xadj <= bx_hi);
		y_ok  = (yadj >= by_lo) && (yadj <= by_hi);
		found = x_ok & y_ok;
	end

	// output and look-ahead control
	assign out_free  = ~out_valid_q | ~out_stall;
	assign scan_adv  = (state_q == S_SCAN) && (!found || !pend_v_q || out_free);
	assign push_pend = scan_adv && found && pend_v_q;
	assign flush_go  = (state_q == S_FLUSH) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dcnt_q  <= '0;
			nx_q    <= '0;
			ny_q    <= '0;
			row_q   <= '0;
			col_q   <= '0;
			trunc_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dcnt_q == DCNT_W'(DIVD_W - 1)) begin
						state_q <= S_FIN;
					end else begin
						dcnt_q <= dcnt_q + DCNT_W'(1);
					end
				end
				S_FIN: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					nx_q    <= nx_d;
					ny_q    <= ny_d;
					row_q   <= '0;
					col_q   <= '0;
					trunc_q <= (!span_x[SPAN_W-1] && span_x >= SPAN_W'(MAX_SPAN))
						|| (!span_y[SPAN_W-1] && span_y >= SPAN_W'(MAX_SPAN));
					state_q <= (nx_d == '0 || ny_d == '0) ? S_FLUSH : S_SCAN;
				end
				S_SCAN: begin
					if (scan_adv) begin
						if (!x_ok || col_q == ny_q - CNT_W'(1)) begin
							col_q <= '0;
							if (row_q == nx_q - CNT_W'(1)) begin
								state_q <= S_FLUSH;
							end else begin
								row_q <= row_q + CNT_W'(1);
							end
						end else begin
							col_q <= col_q + CNT_W'(1);
						end
					end
				end
				S_FLUSH: begin
					if (flush_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// coordinate accumulators
	always_ff @(posedge clk) begin
		if (state_q == S_SETUP) begin
			xr_q <= v0x_q;
			yr_q <= v0y_q;
		end else if (scan_adv) begin
			if (!x_ok || col_q == ny_q - CNT_W'(1)) begin
				xr_q <= xr_q + tce;
				yr_q <= v0y_q;
			end else begin
				yr_q <= yr_q + tce;
			end
		end
	end

	// one-deep look-ahead so the final request can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (scan_adv && found) begin
			pend_v_q <= 1'b1;
		end else if (flush_go) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_adv && found) begin
			pend_x_q <= to_q16(xadj);
			pend_y_q <= to_q16(yadj);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || flush_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend || flush_go) begin
			cell_z_q    <= cz_q;
			blocked_q   <= blk_q;
			truncated_q <= trunc_q;
			last_q      <= flush_go;
			if (push_pend || pend_v_q) begin
				cell_x_q     <= pend_x_q;
				cell_y_q     <= pend_y_q;
				cell_valid_q <= 1'b1;
			end else begin
				cell_x_q     <= '0;
				cell_y_q     <= '0;
				cell_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_x     = cell_x_q;
	assign cell_y     = cell_y_q;
	assign cell_z     = cell_z_q;
	assign blocked    = blocked_q;
	assign cell_valid = cell_valid_q;
	assign truncated  = truncated_q;
	assign last       = last_q;

endmodule
